/* hdl/single_wire_humidity_sensor_reader_assert.svh */
// Assertion macros for the single-wire humidity sensor reader.
// No dependencies; taken in by `include where checks are written.
`ifndef SINGLE_WIRE_HUMIDITY_SENSOR_READER_ASSERT_SVH
`define SINGLE_WIRE_HUMIDITY_SENSOR_READER_ASSERT_SVH
`ifndef SYNTHESIS
// prop must hold at every edge out of reset
`define SWHS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("swhs: assertion failed");
// ante at one edge implies cons at the next
`define SWHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("swhs: assertion failed");
`else
`define SWHS_ASSERT(lbl, clk, rst_n, prop)
`define SWHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/swhs_pkg.sv */
// Package for the single-wire humidity sensor reader: beat types,
// register defaults, status codes and frame constants. No dependencies.
package swhs_pkg;

	localparam int FRAME_BITS      = 40;
	localparam int INTERVALS_DEF   = 84;
	localparam int EDGE_W          = 7;
	localparam int FIRST_DATA_EDGE = 4;
	localparam int LAST_DATA_EDGE  = FIRST_DATA_EDGE + 2 * (FRAME_BITS - 1);

	localparam logic [15:0] PRE_HIGH_RST  = 16'd100;
	localparam logic [15:0] START_LOW_RST = 16'd500;
	localparam logic [15:0] THRESHOLD_RST = 16'd150;
	localparam logic [15:0] TIMEOUT_RST   = 16'd1400;

	localparam logic [1:0] CFG_PRE_HIGH  = 2'd0;
	localparam logic [1:0] CFG_START_LOW = 2'd1;
	localparam logic [1:0] CFG_THRESHOLD = 2'd2;
	localparam logic [1:0] CFG_TIMEOUT   = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_CHECKSUM = 2'd1;
	localparam logic [1:0] ST_NORESP   = 2'd2;
	localparam logic [1:0] ST_TIMEOUT  = 2'd3;

	typedef struct packed {
		logic line_level;
		logic start_read;
	} sample_t;

	typedef struct packed {
		logic               drive_low;
		logic               busy_res;
		logic               result_valid;
		logic [1:0]         status;
		logic [15:0]        humidity_tenths;
		logic signed [15:0] temperature_tenths;
	} res_t;

	typedef struct packed {
		logic        sum_ok;
		logic [15:0] humidity;
		logic [15:0] temperature;
	} decode_t;

endpackage

/* hdl/single_wire_humidity_sensor_reader.sv */
// Top level of the single-wire humidity sensor reader.
// Depends on swhs_pkg, swhs_decode, swhs_skid and the assertion header.
//
// Usage:
//   sample channel (sample_valid/sample_stall/sample): one beat per line
//   sample tick, carrying the sampled line level and a start request.
//   res channel (res_valid/res_stall/res): exactly one beat per sample
//   beat, showing drive_low and busy_res after that tick, and on the tick
//   a frame ends result_valid with status and the decoded readings.
//   cfg port (cfg_we/cfg_index/cfg_data): writes the four 16-bit timing
//   registers; write only while no sample beat is in flight.
// Output: each res beat is registered in the output buffer before it shows on res.
// Throughput: one sample beat per cycle while sample_stall is low; the
//   frame next-state logic and the decoder are combinational, so beats may come back to back.
// Stall: a two-entry output buffer absorbs one beat while res is stalled;
//   sample_stall rises only when both entries are full, and it comes
//   straight from a flop.
// Reset: arst_n clears the frame state to idle, the timing registers to
//   their defaults and empties the output buffer. No clearing pass.
`include "single_wire_humidity_sensor_reader_assert.svh"

module single_wire_humidity_sensor_reader #(
	parameter int INTERVALS = swhs_pkg::INTERVALS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  swhs_pkg::sample_t sample,
	output logic              res_valid,
	input  logic              res_stall,
	output swhs_pkg::res_t    res,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	localparam int EW = swhs_pkg::EDGE_W;

	// frame phases
	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_PRE     = 3'd1;
	localparam logic [2:0] PH_START   = 3'd2;
	localparam logic [2:0] PH_CHECK   = 3'd3;
	localparam logic [2:0] PH_MEASURE = 3'd4;

	localparam logic [EW-1:0] INTERVALS_V  = EW'(INTERVALS);
	localparam logic [EW-1:0] FIRST_DATA_V = EW'(swhs_pkg::FIRST_DATA_EDGE);
	localparam logic [EW-1:0] LAST_DATA_V  = EW'(swhs_pkg::LAST_DATA_EDGE);

	// timing registers
	logic [15:0] pre_high_q;
	logic [15:0] start_low_q;
	logic [15:0] threshold_q;
	logic [15:0] timeout_q;

	// frame state
	logic [2:0]                       phase_q;
	logic [15:0]                      count_q;
	logic [EW-1:0]                    edge_q;
	logic [swhs_pkg::FRAME_BITS-1:0]  frame_q;
	logic                             expect_q;

	logic [2:0]                       phase_d;
	logic [15:0]                      count_d;
	logic [EW-1:0]                    edge_d;
	logic [swhs_pkg::FRAME_BITS-1:0]  frame_d;
	logic                             expect_d;

	logic [16:0]        count_ext;
	logic [15:0]        count_inc;
	logic [EW-1:0]      edge_inc;
	logic               data_edge;
	logic               push;
	logic               buf_full;
	swhs_pkg::res_t     beat;
	swhs_pkg::decode_t  dec;

	assign push         = sample_valid && !buf_full;
	assign sample_stall = buf_full;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_high_q  <= swhs_pkg::PRE_HIGH_RST;
			start_low_q <= swhs_pkg::START_LOW_RST;
			threshold_q <= swhs_pkg::THRESHOLD_RST;
			timeout_q   <= swhs_pkg::TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				swhs_pkg::CFG_PRE_HIGH:  pre_high_q  <= cfg_data;
				swhs_pkg::CFG_START_LOW: start_low_q <= cfg_data;
				swhs_pkg::CFG_THRESHOLD: threshold_q <= cfg_data;
				swhs_pkg::CFG_TIMEOUT:   timeout_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// one tick of the frame state machine
	assign count_ext = {1'b0, count_q} + 17'd1;
	assign count_inc = count_q + 16'd1;
	assign edge_inc  = edge_q + 1'b1;
	// high intervals of the data bits sit on even edges from the first
	// data edge through the last one
	assign data_edge = (edge_q >= FIRST_DATA_V) && !edge_q[0] && (edge_q <= LAST_DATA_V);

	swhs_decode u_decode (
		.frame (frame_d),
		.dec   (dec)
	);

	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		edge_d   = edge_q;
		frame_d  = frame_q;
		expect_d = expect_q;
		beat     = '0;
		unique case (phase_q)
			PH_IDLE: begin
				if (sample.start_read) begin
					phase_d = PH_PRE;
					count_d = '0;
				end
			end
			PH_PRE: begin
				if (count_ext >= {1'b0, pre_high_q}) begin
					phase_d = PH_START;
					count_d = '0;
				end else begin
					count_d = count_inc;
				end
			end
			PH_START: begin
				if (count_ext >= {1'b0, start_low_q}) begin
					phase_d = PH_CHECK;
					count_d = '0;
				end else begin
					count_d = count_inc;
				end
			end
			PH_CHECK: begin
				if (sample.line_level) begin
					phase_d  = PH_MEASURE;
					count_d  = '0;
					edge_d   = '0;
					frame_d  = '0;
					expect_d = 1'b1;
				end else begin
					// sensor did not answer the start pulse
					phase_d           = PH_IDLE;
					count_d           = '0;
					beat.result_valid = 1'b1;
					beat.status       = swhs_pkg::ST_NORESP;
				end
			end
			PH_MEASURE: begin
				if (sample.line_level == expect_q) begin
					count_d = count_inc;
					// wrap to zero also counts as timeout
					if (count_inc >= timeout_q || count_inc == '0) begin
						phase_d           = PH_IDLE;
						count_d           = '0;
						beat.result_valid = 1'b1;
						beat.status       = swhs_pkg::ST_TIMEOUT;
					end
				end else begin
					if (data_edge) begin
						frame_d = {frame_q[swhs_pkg::FRAME_BITS-2:0], (count_q > threshold_q)};
					end
					edge_d   = edge_inc;
					expect_d = ~expect_q;
					count_d  = '0;
					if (edge_inc >= INTERVALS_V) begin
						phase_d           = PH_IDLE;
						beat.result_valid = 1'b1;
						if (dec.sum_ok) begin
							beat.status             = swhs_pkg::ST_OK;
							beat.humidity_tenths    = dec.humidity;
							beat.temperature_tenths = dec.temperature;
						end else begin
							beat.status = swhs_pkg::ST_CHECKSUM;
						end
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
				count_d = '0;
			end
		endcase
		beat.drive_low = (phase_d == PH_START);
		beat.busy_res  = (phase_d != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			count_q  <= '0;
			edge_q   <= '0;
			frame_q  <= '0;
			expect_q <= 1'b1;
		end else if (push) begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			edge_q   <= edge_d;
			frame_q  <= frame_d;
			expect_q <= expect_d;
		end
	end

	swhs_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (beat),
		.full      (buf_full),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// checks
	`SWHS_ASSERT(a_idle_fields_zero, clk, arst_n, !res_valid || res.result_valid || (res.status == swhs_pkg::ST_OK && res.humidity_tenths == '0 && res.temperature_tenths == '0))
	`SWHS_ASSERT(a_finish_is_idle, clk, arst_n, !(res_valid && res.result_valid) || (!res.busy_res && !res.drive_low))
	`SWHS_ASSERT(a_edge_bounded, clk, arst_n, edge_q <= INTERVALS_V)
	`SWHS_ASSERT_NEXT(a_skid_fills_on_stall, clk, arst_n, push && res_valid && res_stall, sample_stall)

endmodule

/* hdl/swhs_decode.sv */
// Frame decoder: byte checksum, humidity word and sign-magnitude temperature.
// Depends on swhs_pkg.
module swhs_decode (
	input  logic [swhs_pkg::FRAME_BITS-1:0] frame,
	output swhs_pkg::decode_t               dec
);

	logic [7:0]  b0, b1, b2, b3, b4;
	logic [7:0]  sum;
	logic [15:0] mag;

	assign b0  = frame[39:32];
	assign b1  = frame[31:24];
	assign b2  = frame[23:16];
	assign b3  = frame[15:8];
	assign b4  = frame[7:0];
	assign sum = b0 + b1 + b2 + b3;
	// magnitude is 15 bits; negative zero folds to zero by the negate
	assign mag = {1'b0, b2[6:0], b3};

	always_comb begin
		dec.sum_ok      = (sum == b4);
		dec.humidity    = {b0, b1};
		dec.temperature = b2[7] ? (16'd0 - mag) : mag;
	end

endmodule

/* hdl/swhs_skid.sv */
// Two-entry output buffer: result register plus skid register, so the
// input stall is a plain flop. Depends on swhs_pkg.
module swhs_skid (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  swhs_pkg::res_t   push_data,
	output logic             full,
	output logic             res_valid,
	input  logic             res_stall,
	output swhs_pkg::res_t   res
);

	logic           out_valid_q;
	logic           skid_valid_q;
	swhs_pkg::res_t out_q;
	swhs_pkg::res_t skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !res_stall) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !res_stall) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign full      = skid_valid_q;
	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

/* test/single_wire_humidity_sensor_reader_test.sv */
// Self-checking bench for the single-wire humidity sensor reader: drives sample
// beats and checks every res beat against a tick-by-tick predictor of the frame or a typed-in value.
// Depends on swhs_pkg and the single_wire_humidity_sensor_reader top level.
module single_wire_humidity_sensor_reader_test;

	// frame shape
	localparam int HIGH_LOW_INTERVALS = swhs_pkg::INTERVALS_DEF;
	localparam int FIRST_BIT_EDGE     = swhs_pkg::FIRST_DATA_EDGE;
	localparam int LAST_BIT_EDGE      = swhs_pkg::LAST_DATA_EDGE;

	localparam int RANDOM_BEATS = 1750;
	localparam int PHASE_BEATS  = 250;
	localparam int QUIET_BEATS  = 400;   // tail of the run with no idling
	localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
	localparam int CYCLE_LIMIT  = 4000000;

	typedef enum logic [2:0] {PH_IDLE, PH_PRE, PH_START, PH_CHECK, PH_MEASURE} frame_phase_e;

	typedef enum int {
		FK_GOOD, FK_BAD_SUM, FK_NEG_ZERO, FK_ALL_ONES, FK_ALL_ZERO,
		FK_NO_RESPONSE, FK_TIMEOUT, FK_NOISE
	} frame_kind_e;

	typedef struct {
		swhs_pkg::sample_t smp;
		bit                pinned;   // want is typed in, not predicted
		swhs_pkg::res_t    want;
	} directed_row_t;

	localparam swhs_pkg::res_t QUIET = '0;
	localparam swhs_pkg::res_t BUSY =
		'{1'b0, 1'b1, 1'b0, swhs_pkg::ST_OK, 16'd0, 16'sd0};
	localparam swhs_pkg::res_t DRIVING =
		'{1'b1, 1'b1, 1'b0, swhs_pkg::ST_OK, 16'd0, 16'sd0};
	localparam swhs_pkg::res_t NORESP_END =
		'{1'b0, 1'b0, 1'b1, swhs_pkg::ST_NORESP, 16'd0, 16'sd0};
	localparam swhs_pkg::res_t TIMEOUT_END =
		'{1'b0, 1'b0, 1'b1, swhs_pkg::ST_TIMEOUT, 16'd0, 16'sd0};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              sample_valid;
	logic              sample_stall;
	swhs_pkg::sample_t sample;
	logic              res_valid;
	logic              res_stall;
	swhs_pkg::res_t    res;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	// predictor state and its copy of the timing registers
	frame_phase_e sim_phase   = PH_IDLE;
	logic [15:0]  tick_count  = '0;
	logic [6:0]   edge_no     = '0;
	logic [39:0]  bits_seen   = '0;
	logic         wait_level  = 1'b1;
	logic [15:0]  timing_pre_high  = 16'd100;
	logic [15:0]  timing_start_low = 16'd500;
	logic [15:0]  timing_threshold = 16'd150;
	logic [15:0]  timing_timeout   = 16'd1400;

	swhs_pkg::res_t expected_ticks [$];
	swhs_pkg::res_t want;
	int          mismatches = 0;
	int unsigned beats_sent = 0;
	int unsigned cycles = 0;
	bit          idle_off = 1'b0;
	bit          hold_req = 1'b0;

	// Short directed walk, timing registers all zero: every phase lasts one
	// tick and a timeout of zero behaves as one.
	directed_row_t directed_rows [14] = '{
		'{'{1'b0, 1'b0}, 1'b1, QUIET},         // idle out of reset
		'{'{1'b1, 1'b0}, 1'b1, QUIET},
		'{'{1'b0, 1'b1}, 1'b1, BUSY},          // start -> release
		'{'{1'b1, 1'b1}, 1'b1, DRIVING},       // start while busy
		'{'{1'b0, 1'b1}, 1'b1, BUSY},
		'{'{1'b0, 1'b0}, 1'b1, NORESP_END},
		'{'{1'b1, 1'b1}, 1'b0, QUIET},
		'{'{1'b0, 1'b0}, 1'b0, QUIET},
		'{'{1'b1, 1'b1}, 1'b0, QUIET},
		'{'{1'b1, 1'b0}, 1'b1, BUSY},          // sensor answered
		'{'{1'b0, 1'b0}, 1'b0, QUIET},
		'{'{1'b1, 1'b1}, 1'b0, QUIET},
		'{'{1'b1, 1'b0}, 1'b1, TIMEOUT_END},
		'{'{1'b0, 1'b0}, 1'b1, QUIET}
	};

	single_wire_humidity_sensor_reader u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.res          (res),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #10 clk = ~clk;

	// One line tick of the reader; returns the res beat it causes.
	function automatic swhs_pkg::res_t predict_tick(input swhs_pkg::sample_t smp);
		swhs_pkg::res_t r;
		int unsigned    nxt;
		logic [7:0]     b0, b1, b2, b3, b4, csum;
		logic [15:0]    mag;
		r = '0;
		case (sim_phase)
		PH_IDLE: if (smp.start_read) begin
			sim_phase = PH_PRE;
			tick_count = '0;
		end
		PH_PRE: begin
			nxt = tick_count + 1;
			if (nxt >= timing_pre_high) begin
				sim_phase = PH_START;
				tick_count = '0;
			end else
				tick_count = nxt[15:0];
		end
		PH_START: begin
			nxt = tick_count + 1;
			if (nxt >= timing_start_low) begin
				sim_phase = PH_CHECK;
				tick_count = '0;
			end else
				tick_count = nxt[15:0];
		end
		PH_CHECK: if (smp.line_level) begin
			sim_phase = PH_MEASURE;
			tick_count = '0;
			edge_no = '0;
			bits_seen = '0;
			wait_level = 1'b1;
		end else begin
			r.result_valid = 1'b1;
			r.status = swhs_pkg::ST_NORESP;
		end
		PH_MEASURE: if (smp.line_level == wait_level) begin
			tick_count = tick_count + 16'd1;   // 16-bit wrap also aborts
			if (tick_count >= timing_timeout || tick_count == 16'd0) begin
				r.result_valid = 1'b1;
				r.status = swhs_pkg::ST_TIMEOUT;
			end
		end else begin
			// level change closes the interval; even data intervals carry bits
			if (edge_no >= FIRST_BIT_EDGE && edge_no <= LAST_BIT_EDGE && !edge_no[0])
				bits_seen = {bits_seen[38:0], tick_count > timing_threshold};
			edge_no = edge_no + 7'd1;
			wait_level = ~wait_level;
			tick_count = '0;
			if (edge_no >= HIGH_LOW_INTERVALS) begin
				{b0, b1, b2, b3, b4} = bits_seen;
				csum = b0 + b1 + b2 + b3;
				r.result_valid = 1'b1;
				if (csum != b4)
					r.status = swhs_pkg::ST_CHECKSUM;
				else begin
					r.status = swhs_pkg::ST_OK;
					r.humidity_tenths = {b0, b1};
					mag = {1'b0, b2[6:0], b3};
					// sign-magnitude; negative zero folds to zero
					r.temperature_tenths = b2[7] ? -mag : mag;
				end
			end
		end
		default: begin
			sim_phase = PH_IDLE;
			tick_count = '0;
		end
		endcase
		if (r.result_valid) begin
			sim_phase = PH_IDLE;
			tick_count = '0;
		end
		r.drive_low = (sim_phase == PH_START);
		r.busy_res = (sim_phase != PH_IDLE);
		return r;
	endfunction

	// Offer one sample beat, maybe after an idle burst; predict on acceptance.
	task automatic send_beat(input swhs_pkg::sample_t smp, input bit pinned = 1'b0,
			input swhs_pkg::res_t pinned_want = '0);
		swhs_pkg::res_t predicted;
		if (!idle_off && $urandom_range(0, 15) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		sample <= smp;
		sample_valid <= 1'b1;
		do @(posedge clk); while (sample_stall);
		predicted = predict_tick(smp);
		expected_ticks.push_back(pinned ? pinned_want : predicted);
		beats_sent++;
	endtask

	// Sender pause: drops sample_valid, waits until nothing is in flight, then adds slack.
	task automatic wait_drained();
		sample_valid <= 1'b0;
		while (expected_ticks.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// All four timing registers, one per cycle; only while drained.
	task automatic write_timing(input logic [15:0] pre_high, start_low, threshold, timeout);
		logic [1:0]  regs [4] = '{swhs_pkg::CFG_PRE_HIGH, swhs_pkg::CFG_START_LOW,
			swhs_pkg::CFG_THRESHOLD, swhs_pkg::CFG_TIMEOUT};
		logic [15:0] vals [4];
		vals = '{pre_high, start_low, threshold, timeout};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
			case (regs[i])
			swhs_pkg::CFG_PRE_HIGH:  timing_pre_high = vals[i];
			swhs_pkg::CFG_START_LOW: timing_start_low = vals[i];
			swhs_pkg::CFG_THRESHOLD: timing_threshold = vals[i];
			swhs_pkg::CFG_TIMEOUT:   timing_timeout = vals[i];
			endcase
		end
		cfg_we <= 1'b0;
	endtask

	// Line held high until the frame ends (timeout at the latest).
	task automatic run_to_idle();
		while (sim_phase != PH_IDLE) send_beat('{1'b1, 1'b0});
	endtask

	// One measurement as a sensor would answer it, with the given twist.
	task automatic send_frame(input frame_kind_e kind);
		logic [7:0]  hum_hi, hum_lo, tmp_hi, tmp_lo, csum;
		logic [39:0] payload;
		int unsigned max_len, lo, hi, len, abort_at, n;
		int          e;
		logic        lvl;
		hum_hi = 8'($urandom);
		hum_lo = 8'($urandom);
		tmp_hi = 8'($urandom);
		tmp_lo = 8'($urandom);
		case (kind)
		FK_NEG_ZERO: begin
			tmp_hi = 8'h80;
			tmp_lo = 8'h00;
		end
		FK_ALL_ONES: {hum_hi, hum_lo, tmp_hi, tmp_lo} = '1;
		FK_ALL_ZERO: {hum_hi, hum_lo, tmp_hi, tmp_lo} = '0;
		default: ;
		endcase
		csum = hum_hi + hum_lo + tmp_hi + tmp_lo;
		if (kind == FK_BAD_SUM)
			csum = csum + 8'($urandom_range(1, 255));
		payload = {hum_hi, hum_lo, tmp_hi, tmp_lo, csum};
		// longest interval that still survives the timeout
		max_len = (timing_timeout == 16'd0) ? 0 : timing_timeout - 1;
		abort_at = (kind == FK_TIMEOUT) ? $urandom_range(0, HIGH_LOW_INTERVALS - 1)
			: HIGH_LOW_INTERVALS;

		repeat ($urandom_range(0, 3)) send_beat('{1'($urandom), 1'b0});
		send_beat('{1'($urandom), 1'b1});
		while (sim_phase == PH_PRE || sim_phase == PH_START)
			send_beat(swhs_pkg::sample_t'(2'($urandom)));
		send_beat('{kind != FK_NO_RESPONSE, 1'($urandom)});
		if (kind == FK_NOISE)
			for (n = 0; n < 400 && sim_phase == PH_MEASURE; n++)
				send_beat(swhs_pkg::sample_t'(2'($urandom)));

		// follow the predictor's interval position, so noise can hand over here
		while (sim_phase == PH_MEASURE) begin
			e = edge_no;
			lvl = wait_level;
			lo = 0;
			hi = ($urandom_range(0, 3) == 0 || max_len < 2) ? max_len : 2;
			if (e >= FIRST_BIT_EDGE && e <= LAST_BIT_EDGE && e % 2 == 0) begin
				if (payload[39 - (e - FIRST_BIT_EDGE) / 2]) begin
					lo = timing_threshold + 1;
					hi = max_len;
				end else
					hi = (timing_threshold < max_len) ? timing_threshold : max_len;
			end
			if (hi < lo)
				hi = lo;
			len = (e == abort_at) ? max_len + 1 : $urandom_range(hi, lo);
			for (n = 0; n < len && sim_phase == PH_MEASURE; n++)
				send_beat('{lvl, $urandom_range(0, 7) == 0});
			if (sim_phase == PH_MEASURE)
				send_beat('{~lvl, 1'b0});
		end
		run_to_idle();
	endtask

	task automatic check_field(input string field, input int exp_val, input int got_val);
		if (exp_val != got_val) begin
			$error("%s: expected %0d, got %0d", field, exp_val, got_val);
			mismatches++;
		end
	endtask

	// Receiver: random stall bursts, plus one long hold-off on request.
	initial begin
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				res_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (!idle_off && $urandom_range(0, 15) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	// Result checker and watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else if (arst_n && res_valid && !res_stall) begin
			if (expected_ticks.size() == 0) begin
				$error("res beat with nothing pending");
				mismatches++;
			end else begin
				want = expected_ticks.pop_front();
				check_field("drive_low", want.drive_low, res.drive_low);
				check_field("busy_res", want.busy_res, res.busy_res);
				check_field("result_valid", want.result_valid, res.result_valid);
				check_field("status", want.status, res.status);
				check_field("humidity_tenths", want.humidity_tenths, res.humidity_tenths);
				check_field("temperature_tenths", want.temperature_tenths,
					res.temperature_tenths);
			end
		end
	end

	// Stimulus: directed walk, extreme timing, then random frames by phase.
	initial begin
		int unsigned random_start, phase_end, thr;
		frame_kind_e kind;
		logic        lvl;
		arst_n <= 1'b0;
		sample_valid <= 1'b0;
		sample <= '0;
		cfg_we <= 1'b0;
		cfg_index <= swhs_pkg::CFG_PRE_HIGH;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_timing(16'd0, 16'd0, 16'd0, 16'd0);
		foreach (directed_rows[i])
			send_beat(directed_rows[i].smp, directed_rows[i].pinned, directed_rows[i].want);

		// threshold and timeout at their top: a line toggling every tick
		// never times out and every bit decodes as zero
		wait_drained();
		write_timing(16'd1, 16'd1, 16'hFFFF, 16'hFFFF);
		send_beat('{1'b1, 1'b1});
		lvl = 1'b1;
		while (sim_phase != PH_IDLE) begin
			send_beat('{lvl, 1'b0});
			lvl = ~lvl;
		end

		random_start = beats_sent;
		for (int phase_no = 0; beats_sent - random_start < RANDOM_BEATS; phase_no++) begin
			wait_drained();
			if (beats_sent - random_start >= RANDOM_BEATS - QUIET_BEATS)
				idle_off = 1'b1;
			thr = $urandom_range(0, 3);
			if (phase_no == 0)
				write_timing(16'd1, 16'd2, 16'd0, 16'd3);
			else if ($urandom_range(0, 4) == 0)   // timeout too short for some bits
				write_timing(16'($urandom_range(0, 5)), 16'($urandom_range(0, 5)),
					16'(thr), 16'($urandom_range(1, 2)));
			else
				write_timing(16'($urandom_range(0, 5)), 16'($urandom_range(0, 5)),
					16'(thr), 16'(thr + $urandom_range(2, 4)));
			if (phase_no == 0) begin
				// receiver holds off while frames keep coming; one of each kind
				hold_req = 1'b1;
				kind = kind.first();
				do begin
					send_frame(kind);
					kind = kind.next();
				end while (kind != kind.first());
			end
			phase_end = beats_sent + PHASE_BEATS;
			while (beats_sent < phase_end) begin
				case ($urandom_range(0, 15))
				7, 8:    kind = FK_BAD_SUM;
				9:       kind = FK_NEG_ZERO;
				10:      kind = FK_ALL_ONES;
				11:      kind = FK_ALL_ZERO;
				12:      kind = FK_NO_RESPONSE;
				13:      kind = FK_TIMEOUT;
				14, 15:  kind = FK_NOISE;
				default: kind = FK_GOOD;
				endcase
				send_frame(kind);
			end
		end

		wait_drained();
		if (mismatches == 0 && expected_ticks.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
